/* sv/rsa_pkg.sv */
// Shared types, constants and codes of the rotating slot allocator.
package rsa_pkg;

   localparam int MaxSlots    = 64;
   localparam int SlotW       = $clog2(MaxSlots);
   localparam int SizeW       = 7;
   localparam int DefaultPool = 4;
   localparam int DimW        = 16;
   localparam int FmtW        = 6;
   localparam int IdxW        = 7;

   typedef logic [MaxSlots-1:0] slot_vec_type;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_RESET   = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_GRANTED = 2'd0,
      STS_BAD_GEO = 2'd1,
      STS_FULL    = 2'd2,
      STS_DONE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_CLAIM
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic finish;
   } cmd_type;

   // Map the requested pool size onto the usable range.
   function automatic logic [SizeW-1:0] effective_size(input logic [SizeW-1:0] req);
      logic [SizeW-1:0] n;
      n = (req == '0) ? SizeW'(DefaultPool) : req;
      if (n > SizeW'(MaxSlots)) begin
         n = SizeW'(MaxSlots);
      end
      return n;
   endfunction

endpackage

/* sv/rsa_channels.sv */
// Request, response and register-write channel interfaces of the slot allocator.
interface rsa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] frame_width;
   logic [15:0] frame_height;
   logic [5:0]  pixel_format;
   logic [6:0]  slot_index;
   modport source (output valid, op, frame_width, frame_height, pixel_format, slot_index,
                   input ready);
   modport sink   (input valid, op, frame_width, frame_height, pixel_format, slot_index,
                   output ready);
endinterface

interface rsa_rsp_if;
   logic       valid;
   logic       ready;
   logic       granted;
   logic [5:0] slot;
   logic [1:0] status;
   modport source (output valid, granted, slot, status, input ready);
   modport sink   (input valid, granted, slot, status, output ready);
endinterface

interface rsa_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] pool_size;
   modport source (output valid, pool_size, input ready);
   modport sink   (input valid, pool_size, output ready);
endinterface

/* sv/rsa_ctrl.sv */
// Controller state machine of the slot allocator: sequences each request and holds the response valid.
module rsa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsa_pkg::cmd_type cmd
);
   import rsa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_PREP;
         ST_PREP:  state_in = ST_CLAIM;
         ST_CLAIM: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_PREP:  cmd.prep = 1'b1;
         ST_CLAIM: cmd.finish = out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // Hold the response until taken; a new one loads only into a free slot.
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/rsa_datapath.sv */
// Datapath of the slot allocator: bitmap, start pointer, geometry cache and rotating pick.
module rsa_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rsa_pkg::cmd_type cmd,
   input  logic [1:0]       req_op,
   input  logic [15:0]      req_frame_width,
   input  logic [15:0]      req_frame_height,
   input  logic [5:0]       req_pixel_format,
   input  logic [6:0]       req_slot_index,
   input  logic             csr_write,
   input  logic [6:0]       csr_pool_size,
   output logic             rsp_granted,
   output logic [5:0]       rsp_slot,
   output logic [1:0]       rsp_status
);
   import rsa_pkg::*;

   function automatic logic [SlotW-1:0] onehot_index(input slot_vec_type v);
      logic [SlotW-1:0] idx;
      idx = '0;
      for (int i = 0; i < MaxSlots; i++) begin
         if (v[i]) idx = idx | SlotW'(i);
      end
      return idx;
   endfunction

   // Captured request
   op_type            op_ff;
   logic [DimW-1:0]   width_ff, height_ff;
   logic [FmtW-1:0]   format_ff;
   logic [IdxW-1:0]   index_ff;

   // Pool state
   logic [SizeW-1:0]  pool_size_ff;
   logic [SizeW-1:0]  size_ff;
   slot_vec_type      in_use_ff, in_use_in;
   logic [SlotW-1:0]  start_ff, start_in;
   logic [DimW-1:0]   cached_width_ff, cached_height_ff;
   logic [FmtW-1:0]   cached_format_ff;
   logic              cache_load;

   // Candidate vectors between prep and claim
   slot_vec_type      cand_all_ff, cand_hi_ff;

   // Result register
   logic              granted_ff;
   logic [SlotW-1:0]  slot_ff;
   status_type        status_ff;

   logic              geo_ok, geo_new, acquire_ok;
   slot_vec_type      active_mask, eff_bits, free_vec, pick_src, pick_bit;
   logic [SlotW-1:0]  eff_start, pick_idx;
   logic [SizeW-1:0]  start_next;

   assign geo_ok     = (width_ff != '0) && (height_ff != '0) && (format_ff != '0);
   assign acquire_ok = (op_ff == OP_ACQUIRE) && geo_ok;
   assign geo_new    = (width_ff != cached_width_ff) || (height_ff != cached_height_ff)
                       || (format_ff != cached_format_ff);

   assign active_mask = ~({MaxSlots{1'b1}} << size_ff);
   assign eff_bits    = geo_new ? '0 : in_use_ff;
   assign eff_start   = geo_new ? '0 : start_ff;
   assign free_vec    = ~eff_bits & active_mask;

   // Claim: lowest free slot at or after start, else lowest free slot overall.
   assign pick_src   = (cand_hi_ff != '0) ? cand_hi_ff : cand_all_ff;
   assign pick_bit   = pick_src & (~pick_src + slot_vec_type'(1));
   assign pick_idx   = onehot_index(pick_bit);
   assign start_next = ({1'b0, start_ff} + SizeW'(1) == size_ff) ? '0
                       : {1'b0, start_ff} + SizeW'(1);

   always_comb begin
      in_use_in  = in_use_ff;
      start_in   = start_ff;
      cache_load = 1'b0;
      if (cmd.prep) begin
         unique case (op_ff)
            OP_ACQUIRE: if (geo_ok && geo_new) begin
               in_use_in  = '0;
               start_in   = '0;
               cache_load = 1'b1;
            end
            OP_RELEASE: if ({1'b0, index_ff} < (IdxW + 1)'(MaxSlots)) begin
               in_use_in[index_ff[SlotW-1:0]] = 1'b0;
            end
            OP_RESET: begin
               in_use_in = '0;
               start_in  = '0;
            end
            OP_NOP: ;
            default: ;
         endcase
      end else if (cmd.finish && acquire_ok && (cand_all_ff != '0)) begin
         in_use_in[pick_idx] = 1'b1;
         start_in            = start_next[SlotW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff     <= SizeW'(DefaultPool);
         size_ff          <= effective_size(SizeW'(DefaultPool));
         in_use_ff        <= '0;
         start_ff         <= '0;
         cached_width_ff  <= '0;
         cached_height_ff <= '0;
         cached_format_ff <= '0;
      end else begin
         if (csr_write) pool_size_ff <= csr_pool_size;
         in_use_ff <= in_use_in;
         start_ff  <= start_in;
         if (cache_load) begin
            cached_width_ff  <= width_ff;
            cached_height_ff <= height_ff;
            cached_format_ff <= format_ff;
         end else if (cmd.prep && (op_ff == OP_RESET)) begin
            cached_width_ff  <= '0;
            cached_height_ff <= '0;
            cached_format_ff <= '0;
         end
         if (cmd.prep && (op_ff == OP_RESET)) size_ff <= effective_size(pool_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(req_op);
         width_ff  <= req_frame_width;
         height_ff <= req_frame_height;
         format_ff <= req_pixel_format;
         index_ff  <= req_slot_index;
      end
      if (cmd.prep) begin
         cand_all_ff <= free_vec;
         cand_hi_ff  <= free_vec & ({MaxSlots{1'b1}} << eff_start);
      end
      if (cmd.finish) begin
         granted_ff <= 1'b0;
         slot_ff    <= '0;
         status_ff  <= STS_DONE;
         if (op_ff == OP_ACQUIRE) begin
            if (!geo_ok) begin
               status_ff <= STS_BAD_GEO;
            end else if (cand_all_ff == '0) begin
               status_ff <= STS_FULL;
            end else begin
               granted_ff <= 1'b1;
               slot_ff    <= pick_idx;
               status_ff  <= STS_GRANTED;
            end
         end
      end
   end

   assign rsp_granted = granted_ff;
   assign rsp_slot    = slot_ff;
   assign rsp_status  = status_ff;

endmodule

/* sv/rotating_slot_allocator_core.sv */
// Top level of the rotating slot allocator: controller, datapath and channel wiring.
//
// Frame-buffer slot allocator over a 64-slot in-use bitmap. A request is an
// acquire, a release, a pool reset or a no-op, and every request returns
// exactly one response. An acquire with a zero width, height or format
// returns bad geometry; a geometry differing from the cached one recaches it
// and frees all slots first. An acquire claims the first free slot at or
// after a rotating start pointer (which then advances by one modulo the
// active size), or reports full. The pool_size register takes effect at the
// next pool reset (0 means 4, values above 64 mean 64); write it only while
// the block is idle. A request is accepted in the idle state, the prep state
// builds the free-slot candidate masks, and the claim state picks the slot
// and loads the response register, which drives response valid; the block
// then returns to the idle state to take the next request.
// A pending response does not block acceptance; only a claim that finds the
// response register still occupied waits for it to be taken.
module rotating_slot_allocator_core (
   input  logic clock,
   input  logic reset,
   rsa_req_if.sink   req_if,
   rsa_rsp_if.source rsp_if,
   rsa_csr_if.sink   csr_if
);
   import rsa_pkg::*;

   cmd_type cmd;

   // Register writes are always taken; the written size takes effect at a reset request.
   assign csr_if.ready = 1'b1;

   // Sequence each request: capture, prep, claim.
   rsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // Hold the pool state and compute the rotating pick.
   rsa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_op           (req_if.op),
      .req_frame_width  (req_if.frame_width),
      .req_frame_height (req_if.frame_height),
      .req_pixel_format (req_if.pixel_format),
      .req_slot_index   (req_if.slot_index),
      .csr_write        (csr_if.valid),
      .csr_pool_size    (csr_if.pool_size),
      .rsp_granted      (rsp_if.granted),
      .rsp_slot         (rsp_if.slot),
      .rsp_status       (rsp_if.status)
   );

endmodule

/* dv/rotating_slot_allocator_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the rotating slot allocator core.
module rotating_slot_allocator_core_tb;
   import rsa_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int SettleCycles  = 8;
   localparam int PhaseItems    = 67;

   typedef struct {
      op_type      op;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [5:0]  pixel_format;
      logic [6:0]  slot_index;
   } alloc_req_type;

   typedef struct {
      logic       granted;
      logic [5:0] slot;
      status_type status;
   } alloc_rsp_type;

   // Mirror of the allocator state; predicts one response per accepted request.
   class alloc_scoreboard;
      logic [63:0]   in_use;
      logic [5:0]    start_ptr;
      logic [15:0]   cached_w;
      logic [15:0]   cached_h;
      logic [5:0]    cached_fmt;
      logic [6:0]    active_slots;
      logic [6:0]    pool_size_reg;
      alloc_rsp_type awaited_rsps[$];
      int            errors;

      function new();
         pool_size_reg = 7'd4;
         active_slots  = 7'd4;
         errors        = 0;
         clear_pool();
      endfunction

      function void clear_pool();
         in_use     = '0;
         start_ptr  = '0;
         cached_w   = '0;
         cached_h   = '0;
         cached_fmt = '0;
      endfunction

      function logic [6:0] usable_slots(logic [6:0] req);
         logic [6:0] n;
         n = (req == 7'd0) ? 7'd4 : req;
         if (n > 7'd64) begin
            n = 7'd64;
         end
         return n;
      endfunction

      function void set_pool_size(logic [6:0] value);
         pool_size_reg = value;
      endfunction

      function void note_request(alloc_req_type r);
         alloc_rsp_type rsp;
         int            n;
         int            start;
         int            idx;
         logic [63:0]   mask;
         rsp.granted = 1'b0;
         rsp.slot    = '0;
         rsp.status  = STS_DONE;
         case (r.op)
            OP_ACQUIRE: begin
               if (r.frame_width == 0 || r.frame_height == 0 || r.pixel_format == 0) begin
                  rsp.status = STS_BAD_GEO;
               end else begin
                  n = int'(active_slots);
                  if (r.frame_width != cached_w || r.frame_height != cached_h ||
                      r.pixel_format != cached_fmt) begin
                     cached_w   = r.frame_width;
                     cached_h   = r.frame_height;
                     cached_fmt = r.pixel_format;
                     in_use     = '0;
                     start_ptr  = '0;
                  end
                  mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
                  if ((in_use & mask) == mask) begin
                     rsp.status = STS_FULL;
                  end else begin
                     start     = int'(start_ptr) % n;
                     start_ptr = 6'((start + 1) % n);
                     for (int a = 0; a < n; a++) begin
                        idx = (start + a) % n;
                        if (!in_use[idx]) begin
                           in_use[idx] = 1'b1;
                           rsp.granted = 1'b1;
                           rsp.slot    = 6'(idx);
                           rsp.status  = STS_GRANTED;
                           break;
                        end
                     end
                  end
               end
            end
            OP_RELEASE: begin
               if (r.slot_index < 7'd64) begin
                  in_use[r.slot_index[5:0]] = 1'b0;
               end
            end
            OP_RESET: begin
               clear_pool();
               active_slots = usable_slots(pool_size_reg);
            end
            default: begin
            end
         endcase
         awaited_rsps.push_back(rsp);
      endfunction

      function void check_response(alloc_rsp_type got);
         alloc_rsp_type want;
         if (awaited_rsps.size() == 0) begin
            $error("response with no request pending: granted %0d slot %0d status %0d",
                   got.granted, got.slot, got.status);
            errors++;
            return;
         end
         want = awaited_rsps.pop_front();
         if (got.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, got.granted);
            errors++;
         end
         if (got.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   rsa_req_if req_if ();
   rsa_rsp_if rsp_if ();
   rsa_csr_if csr_if ();

   alloc_scoreboard sb = new();

   int send_idle_pct;
   int rcv_idle_pct;

   rotating_slot_allocator_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sample responses with pre-edge values; throttle ready per the current mode.
   always @(posedge clock) begin
      alloc_rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.granted = rsp_if.granted;
         got.slot    = rsp_if.slot;
         got.status  = status_type'(rsp_if.status);
         sb.check_response(got);
      end
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Count cycles without any handshake; give up when the limit is hit.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("rotating_slot_allocator_core_tb: errors");
      $finish;
   end

   // Present one request, hold it until accepted, then log it with the scoreboard.
   // Call at a rising edge; valid stays high on return so back-to-back requests
   // never toggle it within one step.
   task automatic send(input op_type op, input logic [15:0] w, input logic [15:0] h,
                       input logic [5:0] f, input logic [6:0] idx);
      alloc_req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      r.op           = op;
      r.frame_width  = w;
      r.frame_height = h;
      r.pixel_format = f;
      r.slot_index   = idx;
      req_if.valid        <= 1'b1;
      req_if.op           <= op;
      req_if.frame_width  <= w;
      req_if.frame_height <= h;
      req_if.pixel_format <= f;
      req_if.slot_index   <= idx;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sb.note_request(r);
   endtask

   // Drop valid and wait until every pending response has been taken, then settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.awaited_rsps.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write the pool size register; call only while the block is idle.
   task automatic write_pool_size(input logic [6:0] value);
      csr_if.valid     <= 1'b1;
      csr_if.pool_size <= value;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      csr_if.valid <= 1'b0;
      sb.set_pool_size(value);
   endtask

   // Issue one random request; most acquires reuse the phase geometry so slots
   // actually fill, the rest change it or break it.
   task automatic send_random(input logic [37:0] geo_a, input logic [37:0] geo_b);
      int          pick;
      int          g;
      logic [15:0] w;
      logic [15:0] h;
      logic [5:0]  f;
      logic [6:0]  idx;
      pick = $urandom_range(99);
      w    = 16'($urandom);
      h    = 16'($urandom);
      f    = 6'($urandom);
      idx  = 7'($urandom);
      if (pick < 60) begin
         g = $urandom_range(99);
         if (g < 80) begin
            {w, h, f} = geo_a;
         end else if (g < 92) begin
            {w, h, f} = geo_b;
         end else begin
            if ($urandom_range(3) == 0) w = '0;
            if ($urandom_range(3) == 0) h = '0;
            if ($urandom_range(3) == 0) f = '0;
         end
         send(OP_ACQUIRE, w, h, f, idx);
      end else if (pick < 90) begin
         if ($urandom_range(3) != 0) begin
            idx = 7'($urandom_range(int'(sb.active_slots) - 1));
         end
         send(OP_RELEASE, w, h, f, idx);
      end else if (pick < 96) begin
         send(OP_NOP, w, h, f, idx);
      end else begin
         send(OP_RESET, w, h, f, idx);
      end
   endtask

   initial begin
      logic [6:0]  sizes[9];
      logic [37:0] geo_a;
      logic [37:0] geo_b;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.op        <= OP_NOP;
      req_if.frame_width  <= '0;
      req_if.frame_height <= '0;
      req_if.pixel_format <= '0;
      req_if.slot_index   <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.pool_size <= '0;
      send_idle_pct    = 0;
      rcv_idle_pct     = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bad geometry on each field, default pool of four filled to full.
      send(OP_ACQUIRE, 16'd0, 16'd100, 6'd5, 7'd0);
      send(OP_ACQUIRE, 16'd100, 16'd0, 6'd5, 7'd0);
      send(OP_ACQUIRE, 16'd100, 16'd100, 6'd0, 7'd0);
      repeat (5) send(OP_ACQUIRE, '1, '1, '1, 7'd0);
      // Free a slot in the middle and reclaim it through the rotating search.
      send(OP_RELEASE, 16'd0, 16'd0, 6'd0, 7'd2);
      send(OP_ACQUIRE, '1, '1, '1, '1);
      // Releases out of range, beyond the active size, and of a free slot.
      send(OP_RELEASE, '1, '1, '1, 7'd127);
      send(OP_RELEASE, 16'd0, 16'd0, 6'd0, 7'd64);
      send(OP_RELEASE, 16'd0, 16'd0, 6'd0, 7'd63);
      send(OP_RELEASE, 16'd0, 16'd0, 6'd0, 7'd0);
      send(OP_RELEASE, 16'd0, 16'd0, 6'd0, 7'd0);
      send(OP_NOP, '1, '1, '1, '1);
      // New geometry frees everything and restarts at slot zero.
      send(OP_ACQUIRE, 16'd1, 16'd1, 6'd1, 7'd0);
      // Register written without a pool reset: the old size stays in force.
      drain();
      write_pool_size(7'd1);
      send(OP_ACQUIRE, 16'd1, 16'd1, 6'd1, 7'd0);
      send(OP_RESET, '1, '1, '1, '1);
      send(OP_ACQUIRE, 16'd1, 16'd1, 6'd1, 7'd0);
      send(OP_ACQUIRE, 16'd1, 16'd1, 6'd1, 7'd0);

      // Random phases: extremes of the register first, then random sizes.
      sizes[0] = 7'd0;
      sizes[1] = 7'd1;
      sizes[2] = 7'd64;
      sizes[3] = 7'd127;
      sizes[4] = 7'd2;
      sizes[5] = 7'd65;
      sizes[6] = 7'($urandom_range(8, 3));
      sizes[7] = 7'($urandom_range(127, 1));
      sizes[8] = 7'($urandom_range(127));
      for (int p = 0; p < 9; p++) begin
         drain();
         write_pool_size(sizes[p]);
         // Select idling mode: slow receiver, then slow sender, then none.
         if (p < 3) begin
            send_idle_pct = 38;
            rcv_idle_pct  = 70;
         end else if (p < 6) begin
            send_idle_pct = 70;
            rcv_idle_pct  = 38;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         geo_a = {16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                  6'($urandom_range(63, 1))};
         geo_b = {16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                  6'($urandom_range(63, 1))};
         send(OP_RESET, 16'($urandom), 16'($urandom), 6'($urandom), 7'($urandom));
         for (int i = 0; i < PhaseItems; i++) begin
            // Hold the sender once until the pipeline is empty.
            if (p == 4 && i == PhaseItems / 2) begin
               drain();
            end
            send_random(geo_a, geo_b);
         end
      end

      drain();
      if (sb.awaited_rsps.size() != 0) begin
         $error("%0d responses never arrived", sb.awaited_rsps.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("rotating_slot_allocator_core_tb: clean");
      end else begin
         $display("rotating_slot_allocator_core_tb: errors");
      end
      $finish;
   end

endmodule
